FILE: rtl/core/olt_pkg.sv
package olt_pkg;

  // Field widths of the request and result beats.
  localparam int CMD_W = 3;
  localparam int VALUE_W = 32;
  localparam int TAG_W = 8;
  localparam int POS_W = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // One stored list entry.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  // Request beat.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] item_value;
    logic [TAG_W-1:0]          item_tag;
    logic [POS_W-1:0]          position;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] out_value;
    logic [TAG_W-1:0]          out_tag;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_SWEEP_READ,
    CELL_SWEEP_FIND
  } cell_op_t;

  // Broadcast control: the operation and the entry to write or to match.
  typedef struct packed {
    cell_op_t op;
    entry_t   wr;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/ordered_list_table.sv
// Insert, pop, clear and rejected requests: the result strobe is registered at
// the accepting edge, and a new request may be accepted every cycle.
// Read and delete: the lane sweeps over the cell chain in S_SWEEP, then S_FINISH
// registers the result strobe; busy stays high until the return to idle, so no
// new request is taken during the sweep.
// Reset empties the list and returns to idle; entries are not cleared.
module ordered_list_table
  import olt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
  localparam logic [CW-1:0] SWEEP_LAST = CW'(CAPACITY - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] sweep_cnt, sweep_cnt_next;
  cell_op_t mode, mode_next;
  entry_t key, key_next;
  logic [IW-1:0] pos_r, pos_next;
  rsp_t rsp_next;
  logic done_next;

  cell_ctrl_t cell_ctrl;
  logic [IW-1:0] cell_at;
  entry_t req_entry;
  logic [PW-1:0] pos_x, cnt_x;

  entry_t entries [CAPACITY];
  logic lane_hit [CAPACITY+1];
  entry_t lane_entry [CAPACITY+1];
  logic [IW-1:0] lane_idx [CAPACITY+1];

  assign busy = (state != S_IDLE);
  assign req_entry = '{value: req.item_value, tag: req.item_tag};
  assign pos_x = PW'(req.position);
  assign cnt_x = PW'(count);

  // The lane enters empty past the tail.
  assign lane_hit[CAPACITY] = 1'b0;
  assign lane_entry[CAPACITY] = '0;
  assign lane_idx[CAPACITY] = '0;

  // Chain of cells, one list slot each.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = cell_ctrl.wr;
    end else begin : g_mid_l
      assign left_in = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = entries[i];
    end else begin : g_mid_r
      assign right_in = entries[i+1];
    end
    olt_cell #(
      .INDEX (i),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .at         (cell_at),
      .count      (count),
      .left       (left_in),
      .right      (right_in),
      .feed_hit   (lane_hit[i+1]),
      .feed_entry (lane_entry[i+1]),
      .feed_idx   (lane_idx[i+1]),
      .entry      (entries[i]),
      .lane_hit   (lane_hit[i]),
      .lane_entry (lane_entry[i]),
      .lane_idx   (lane_idx[i])
    );
  end

  // Request decode, sweep sequencing and result formation.
  always_comb begin
    cell_ctrl = '{op: CELL_HOLD, wr: req_entry};
    cell_at = '0;
    state_next = state;
    count_next = count;
    sweep_cnt_next = sweep_cnt;
    mode_next = mode;
    key_next = key;
    pos_next = pos_r;
    done_next = 1'b0;
    rsp_next = '{status: ST_OK, out_value: '0, out_tag: '0, entry_count: '0};
    case (state)
      S_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          case (req.cmd)
            CMD_INSERT: begin
              if (count == '0) begin
                cell_ctrl.op = CELL_OPEN;
                count_next = CW'(1);
              end else if (pos_x > cnt_x) begin
                rsp_next.status = ST_RANGE;
              end else if (count == FULL_COUNT) begin
                rsp_next.status = ST_FULL;
              end else begin
                cell_ctrl.op = CELL_OPEN;
                cell_at = IW'(req.position);
                count_next = count + CW'(1);
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rsp_next.out_value = entries[0].value;
                rsp_next.out_tag = entries[0].tag;
                cell_ctrl.op = CELL_CLOSE;
                count_next = count - CW'(1);
              end
            end
            CMD_DELETE: begin
              if (count == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                done_next = 1'b0;
                state_next = S_SWEEP;
                mode_next = CELL_SWEEP_FIND;
                key_next = req_entry;
                sweep_cnt_next = '0;
              end
            end
            CMD_READ: begin
              if (count == '0) begin
                rsp_next.status = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                rsp_next.status = ST_RANGE;
              end else begin
                done_next = 1'b0;
                state_next = S_SWEEP;
                mode_next = CELL_SWEEP_READ;
                pos_next = IW'(req.position);
                sweep_cnt_next = '0;
              end
            end
            CMD_CLEAR: begin
              if (count == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                count_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        cell_ctrl = '{op: mode, wr: key};
        cell_at = pos_r;
        sweep_cnt_next = sweep_cnt + CW'(1);
        if (sweep_cnt == SWEEP_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
        done_next = 1'b1;
        if (lane_hit[0]) begin
          rsp_next.out_value = lane_entry[0].value;
          rsp_next.out_tag = lane_entry[0].tag;
          if (mode == CELL_SWEEP_FIND) begin
            cell_ctrl.op = CELL_CLOSE;
            cell_at = lane_idx[0];
            count_next = count - CW'(1);
          end
        end else begin
          rsp_next.status = ST_NOTFOUND;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rsp_next.entry_count = COUNT_W'(count_next);
  end

  // State, count and the registered result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sweep_cnt <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      sweep_cnt <= sweep_cnt_next;
      done <= done_next;
    end
    mode <= mode_next;
    key <= key_next;
    pos_r <= pos_next;
    rsp <= rsp_next;
  end

  // A result beat follows only an accepted request or the end of a sweep.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH || (start && state == S_IDLE)))
    else $error("result beat without a cause");

  // The reported count tracks the held count.
  a_count_report: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.entry_count == COUNT_W'(count))
    else $error("entry_count differs from the list count");

  // A validated read always finds its slot on the lane.
  a_read_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && mode == CELL_SWEEP_READ) |-> lane_hit[0])
    else $error("read sweep ended without a hit");

  // A sweep only continues or finishes.
  a_sweep_flow: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |=> (state == S_SWEEP || state == S_FINISH))
    else $error("sweep left without finishing");

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("count above capacity");

endmodule

FILE: rtl/core/olt_cell.sv
module olt_cell
  import olt_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [IW-1:0] at,
  input  logic [CW-1:0] count,
  input  entry_t        left,
  input  entry_t        right,
  input  logic          feed_hit,
  input  entry_t        feed_entry,
  input  logic [IW-1:0] feed_idx,
  output entry_t        entry,
  output logic          lane_hit,
  output entry_t        lane_entry,
  output logic [IW-1:0] lane_idx
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_POS = CW'(INDEX);

  logic sel;

  // A cell claims the lane when it holds the addressed or the matching entry.
  always_comb begin
    case (ctrl.op)
      CELL_SWEEP_READ: sel = (MY_IDX == at);
      CELL_SWEEP_FIND: sel = (entry == ctrl.wr) && (MY_POS < count);
      default:         sel = 1'b0;
    endcase
  end

  // Entry storage shifts with its neighbors; the lane moves one cell toward
  // the head per cycle, so the lowest claiming cell wins at the head.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_OPEN: begin
        if (MY_IDX == at) begin
          entry <= ctrl.wr;
        end else if (MY_IDX > at) begin
          entry <= left;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= at) begin
          entry <= right;
        end
      end
      CELL_SWEEP_READ, CELL_SWEEP_FIND: begin
        if (sel) begin
          lane_hit   <= 1'b1;
          lane_entry <= entry;
          lane_idx   <= MY_IDX;
        end else begin
          lane_hit   <= feed_hit;
          lane_entry <= feed_entry;
          lane_idx   <= feed_idx;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
